// ===== sv/sfe_pkg.sv =====
// Shared constants and control/status types of the simplex boundary face enumerator.
package sfe_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_DIM      = 7;
  localparam int IDX_W        = 49;
  localparam int DIM_W        = 3;
  localparam int VTX_W        = 8;
  localparam int N_W          = $clog2(MAX_VERTICES + 1);
  localparam int K_W          = $clog2(MAX_DIM + 2);
  localparam int TABLE_DEPTH  = (MAX_DIM + 2) * (MAX_VERTICES + 1);
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic load_in;
    logic chk_rd;
    logic start_walk;
    logic init_vtx;
    logic probe_step;
    logic emit;
    logic emit_err;
  } sfe_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic range_err;
    logic span_open;
    logic step_open;
    logic k_zero;
    logic out_free;
  } sfe_stat_t;

endpackage

// ===== sv/sfe_table.sv =====
// Binomial coefficient memory, built row by row after reset, with one registered read port.
module sfe_table
  import sfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [K_W-1:0]   rd_k,
  input  logic [N_W-1:0]   rd_n,
  output logic [IDX_W-1:0] rd_data,
  output logic             fill_done
);

  localparam logic [K_W-1:0] K_TOP = K_W'(MAX_DIM + 1);
  localparam logic [N_W-1:0] N_TOP = N_W'(MAX_VERTICES);

  logic [IDX_W-1:0] mem [TABLE_DEPTH];

  // last MAX_DIM+2 coefficients written, back into the previous row; shifted once per write
  logic [IDX_W-1:0] row [MAX_DIM + 2];
  logic [K_W-1:0]   fill_k;
  logic [N_W-1:0]   fill_n;
  logic [IDX_W-1:0] fill_val;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  function automatic logic [ADDR_W-1:0] tbl_addr(logic [K_W-1:0] k, logic [N_W-1:0] n);
    return ADDR_W'(k) * ADDR_W'(MAX_VERTICES + 1) + ADDR_W'(n);
  endfunction

  assign fill_val = (fill_k == '0) ? IDX_W'(1) : row[MAX_DIM + 1] + row[MAX_DIM];
  assign wr_addr  = tbl_addr(fill_k, fill_n);
  assign rd_addr  = tbl_addr(rd_k, rd_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_k    <= K_TOP;
      fill_n    <= '0;
      fill_done <= 1'b0;
      for (int i = 0; i <= MAX_DIM + 1; i++) begin
        row[i] <= '0;
      end
    end else if (!fill_done) begin
      row[0] <= fill_val;
      for (int i = 1; i <= MAX_DIM + 1; i++) begin
        row[i] <= row[i-1];
      end
      if (fill_k == '0) begin
        fill_k <= K_TOP;
        fill_n <= fill_n + 1'b1;
        if (fill_n == N_TOP) begin
          fill_done <= 1'b1;
        end
      end else begin
        fill_k <= fill_k - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!fill_done) begin
      mem[wr_addr] <= fill_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sfe_ctrl.sv =====
// Controller: waits for the table build, then sequences the range check, the per-vertex search and result emission.
module sfe_ctrl
  import sfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  sfe_stat_t stat,
  output logic      in_ready,
  output sfe_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_FILL   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CHK_RD = 8'b0000_0100,
    ST_CHK    = 8'b0000_1000,
    ST_INIT   = 8'b0001_0000,
    ST_PROBE  = 8'b0010_0000,
    ST_EMIT   = 8'b0100_0000,
    ST_ERR    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_FILL: begin
        if (stat.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (stat.range_err) begin
          state_next = ST_ERR;
        end else begin
          cmd.start_walk = 1'b1;
          state_next     = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_vtx = 1'b1;
        state_next   = stat.span_open ? ST_PROBE : ST_EMIT;
      end
      ST_PROBE: begin
        cmd.probe_step = 1'b1;
        state_next     = stat.step_open ? ST_PROBE : ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the transfer
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.k_zero ? ST_IDLE : ST_INIT;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

endmodule

// ===== sv/sfe_datapath.sv =====
// Datapath: request registers, search bounds, rank accumulators, table and output register.
module sfe_datapath
  import sfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  sfe_cmd_t         cmd,
  output sfe_stat_t        stat,
  input  logic             cfg_we,
  input  logic [N_W-1:0]   cfg_wdata,
  input  logic [IDX_W-1:0] in_index,
  input  logic [DIM_W-1:0] in_dim,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VTX_W-1:0] out_vertex,
  output logic [IDX_W-1:0] out_face,
  output logic             out_last,
  output logic             out_err
);

  logic [N_W-1:0]   vertex_count;
  logic [N_W-1:0]   vc_lim;
  logic [N_W-1:0]   vc_eff;
  logic [IDX_W-1:0] idx;
  logic [DIM_W-1:0] dim;
  logic             pre_err;
  logic [IDX_W-1:0] below;
  logic [IDX_W-1:0] above;
  logic [IDX_W-1:0] c1;
  logic [VTX_W-1:0] top;
  logic [VTX_W-1:0] low;
  logic [VTX_W-1:0] high;
  logic [VTX_W-1:0] mid;
  logic [DIM_W-1:0] k;

  logic [VTX_W-1:0] k_ext;
  logic [VTX_W-1:0] mid_init;
  logic             fits;
  logic [VTX_W-1:0] low_next;
  logic [VTX_W-1:0] high_next;
  logic [IDX_W-1:0] c1_next;
  logic [VTX_W-1:0] mid_next;
  logic             step_open;
  logic             span_open;

  logic             rd_en;
  logic [K_W-1:0]   rd_k;
  logic [N_W-1:0]   rd_n;
  logic [IDX_W-1:0] rd_data;
  logic             fill_done;

  function automatic logic [VTX_W-1:0] upper_mid(logic [VTX_W-1:0] lo, logic [VTX_W-1:0] hi);
    logic [VTX_W:0] s;
    s = {1'b0, lo} + {1'b0, hi} + 1'b1;
    return s[VTX_W:1];
  endfunction

  sfe_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_k      (rd_k),
    .rd_n      (rd_n),
    .rd_data   (rd_data),
    .fill_done (fill_done)
  );

  assign vc_lim = (vertex_count > N_W'(MAX_VERTICES)) ? N_W'(MAX_VERTICES) : vertex_count;

  assign k_ext     = VTX_W'(k);
  assign span_open = k_ext < top;
  assign mid_init  = upper_mid(k_ext, top);

  // one bisection step on the coefficient read for the last probe
  assign fits      = rd_data <= below;
  assign low_next  = fits ? mid : low;
  assign high_next = fits ? high : mid - 1'b1;
  assign c1_next   = fits ? rd_data : c1;
  assign step_open = low_next < high_next;
  assign mid_next  = upper_mid(low_next, high_next);

  always_comb begin
    rd_en = cmd.chk_rd | cmd.init_vtx | cmd.probe_step;
    rd_k  = K_W'(k);
    rd_n  = N_W'(low_next);
    if (cmd.chk_rd) begin
      rd_k = K_W'(dim) + 1'b1;
      rd_n = vc_eff;
    end else if (cmd.init_vtx) begin
      if (span_open) begin
        rd_k = K_W'(k) + 1'b1;
        rd_n = N_W'(mid_init);
      end else begin
        rd_n = N_W'(k_ext);
      end
    end else if (step_open) begin
      rd_k = K_W'(k) + 1'b1;
      rd_n = N_W'(mid_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= N_W'(MAX_VERTICES);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx     <= in_index;
      dim     <= in_dim;
      vc_eff  <= vc_lim;
      pre_err <= (vertex_count == '0) || (N_W'(in_dim) >= vc_lim);
    end
    if (cmd.start_walk) begin
      below <= idx;
      above <= '0;
      top   <= VTX_W'(vc_eff - 1'b1);
      k     <= dim;
    end
    if (cmd.init_vtx) begin
      low  <= k_ext;
      high <= top;
      mid  <= mid_init;
      c1   <= '0;
    end
    if (cmd.probe_step) begin
      low  <= low_next;
      high <= high_next;
      mid  <= mid_next;
      c1   <= c1_next;
    end
    if (cmd.emit) begin
      below <= below - c1;
      above <= above + rd_data;
      top   <= low;
      k     <= k - 1'b1;
    end
  end

  // output register; the face rank is the running upper part plus what is left below
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vertex <= low;
      out_face   <= above + (below - c1);
      out_last   <= (k == '0);
      out_err    <= 1'b0;
    end else if (cmd.emit_err) begin
      out_vertex <= '0;
      out_face   <= '0;
      out_last   <= 1'b1;
      out_err    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.fill_done = fill_done;
  assign stat.range_err = pre_err || (idx >= rd_data);
  assign stat.span_open = span_open;
  assign stat.step_open = step_open;
  assign stat.k_zero    = (k == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== sv/simplex_boundary_face_enumerator.sv =====
// Top level of the simplex boundary face enumerator.
//
// A request on the slave stream carries a simplex as its combinadic rank and its
// dimension d. The master stream returns d+1 transfers, highest vertex first, each
// with the vertex and the rank of the boundary face without it; tlast marks the
// final one. A rank or dimension outside the vertex count set by cfg_wdata gives a
// single transfer with tuser high and tlast high.
// Each vertex is found by bisection over a binomial table memory with a registered
// read port: one cycle per bisection step (at most 8), plus a setup step in ST_INIT
// and an emit step in ST_EMIT per vertex. The range check reads the table in
// ST_CHK_RD and compares in ST_CHK after the accept; a failed check goes to ST_ERR.
// The next request is taken once the last result sits in the output register.
// After reset the table is built by a sweep over all entries, one entry per cycle;
// tready stays low until it ends. Configuration writes are taken at any time.
// When the receiver stalls, the output register holds and the search waits.
module simplex_boundary_face_enumerator
  import sfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [N_W-1:0]   cfg_wdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,   // simplex_index[48:0], dimension[51:49], zero
  input  logic             m_axis_tready,
  output logic             m_axis_tvalid,
  output logic [63:0]      m_axis_tdata,   // vertex[7:0], face_rank[56:8], zero
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // index_error
);

  sfe_cmd_t         cmd;
  sfe_stat_t        stat;
  logic [VTX_W-1:0] out_vertex;
  logic [IDX_W-1:0] out_face;

  sfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  sfe_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_index   (s_axis_tdata[IDX_W-1:0]),
    .in_dim     (s_axis_tdata[IDX_W+DIM_W-1:IDX_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_vertex (out_vertex),
    .out_face   (out_face),
    .out_last   (m_axis_tlast),
    .out_err    (m_axis_tuser)
  );

  assign m_axis_tdata = {{(64 - VTX_W - IDX_W){1'b0}}, out_face, out_vertex};

  a_ready_after_fill: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> stat.fill_done)
    else $error("input ready before table build finished");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error transfer not marked last");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_err) |-> stat.out_free)
    else $error("result loaded over a pending transfer");

endmodule
